>>> rtl/rii_pkg.sv
// ----------------------------------------------------------------------------
// rii_pkg: shared definitions for the rolling integral image block
// Default sizes, configuration register map and field widths.
// ----------------------------------------------------------------------------
package rii_pkg;

  // default sizes
  localparam int MaxWidthDef  = 256;
  localparam int RingDepthDef = 32;

  // field widths
  localparam int PixelW    = 8;
  localparam int IntegralW = 32;
  localparam int ColumnW   = 8;
  localparam int SlotW     = 5;
  localparam int ImgWidthW = 9;
  localparam int RingRowsW = 6;
  localparam int CfgDataW  = 9;
  localparam int CfgIdxW   = 1;
  localparam int OutDataW  = 48;  // 32 + 8 + 5 = 45, padded to whole bytes

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH = 1'b0,
    REG_RING_ROWS   = 1'b1
  } cfg_reg_e;

  // reset values of the registers
  localparam logic [ImgWidthW-1:0] ImgWidthRst = 9'd256;
  localparam logic [RingRowsW-1:0] RingRowsRst = 6'd32;

endpackage

>>> rtl/rii_line_mem.sv
// ----------------------------------------------------------------------------
// rii_line_mem: previous-row line memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rii_line_mem #(
  parameter int Depth = rii_pkg::MaxWidthDef,
  parameter int DataW = rii_pkg::IntegralW,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rolling_integral_image.sv
// ----------------------------------------------------------------------------
// rolling_integral_image: streaming integral image
// Per pixel in raster order: row running sum plus same column of previous row.
// ----------------------------------------------------------------------------
// One pixel beat is taken every clock while the result stream is not stalled;
// a result passes the input register, then the result register. The rate is set
// by the line memory of MAX_WIDTH x 32 bits, which gives one read and one write
// per cycle; a row of a single column, where a pixel needs the value written
// by the pixel just before it, is served by forwarding around the memory.
// Output tdata holds integral_value, column and ring_slot; tlast marks the
// last pixel of a row. The line memory is not cleared: after raising the
// image width mid-frame, start a new frame before relying on results.
module rolling_integral_image #(
  parameter int MAX_WIDTH  = rii_pkg::MaxWidthDef,
  parameter int RING_DEPTH = rii_pkg::RingDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [rii_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rii_pkg::CfgDataW-1:0]  cfg_data_i,
  // pixel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rii_pkg::PixelW-1:0]    s_axis_tdata,  // [7:0] pixel
  input  logic                          s_axis_tuser,  // [0] frame_start
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] integral_value, [39:32] column, [44:40] ring_slot, [47:45] zero
  output logic [rii_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast   // row_end
);

  import rii_pkg::*;

  localparam int ColAw = $clog2(MAX_WIDTH);
  localparam int CntW  = ($clog2(MAX_WIDTH + 1) > ImgWidthW) ?
                         $clog2(MAX_WIDTH + 1) : ImgWidthW;
  localparam int RingW = $clog2(RING_DEPTH);
  localparam int RowW  = ($clog2(RING_DEPTH + 1) > RingRowsW) ?
                         $clog2(RING_DEPTH + 1) : RingRowsW;

  // configuration registers
  logic [ImgWidthW-1:0] img_width_q;
  logic [RingRowsW-1:0] ring_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q <= ImgWidthRst;
      ring_rows_q <= RingRowsRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH: img_width_q <= cfg_data_i;
        REG_RING_ROWS:   ring_rows_q <= cfg_data_i[RingRowsW-1:0];
        default: ;
      endcase
    end
  end

  // effective width and ring height, clamped to their ranges
  logic [CntW-1:0] width_ext, width_eff;
  logic [RowW-1:0] rows_ext, rows_eff;

  always_comb begin
    width_ext = CntW'(img_width_q);
    if (width_ext == '0) begin
      width_eff = CntW'(1);
    end else if (width_ext > CntW'(MAX_WIDTH)) begin
      width_eff = CntW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    rows_ext = RowW'(ring_rows_q);
    if (rows_ext == '0) begin
      rows_eff = RowW'(1);
    end else if (rows_ext > RowW'(RING_DEPTH)) begin
      rows_eff = RowW'(RING_DEPTH);
    end else begin
      rows_eff = rows_ext;
    end
  end

  // handshake
  logic out_valid_q;
  logic s1_valid_q;
  logic s1_adv;
  logic in_acc;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // row state
  logic [ColAw-1:0]     col_q;
  logic [IntegralW-1:0] row_sum_q;
  logic [RingW-1:0]     ring_q;
  logic                 first_q;

  // front end: column, row sum, slot and row end of the incoming pixel
  logic [ColAw-1:0]     col_a;
  logic [IntegralW-1:0] sum_a;
  logic [RingW-1:0]     ring_a;
  logic                 first_a;
  logic                 last_a;
  logic [RingW-1:0]     ring_next;

  always_comb begin
    if (s_axis_tuser) begin
      col_a   = '0;
      sum_a   = IntegralW'(s_axis_tdata);
      ring_a  = '0;
      first_a = 1'b1;
    end else begin
      col_a   = col_q;
      sum_a   = row_sum_q + IntegralW'(s_axis_tdata);
      ring_a  = ring_q;
      first_a = first_q;
    end
    last_a = (CntW'(col_a) + CntW'(1)) >= width_eff;
    if ((RowW'(ring_a) + RowW'(1)) >= rows_eff) begin
      ring_next = '0;
    end else begin
      ring_next = RingW'(RowW'(ring_a) + RowW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_sum_q <= '0;
      ring_q    <= '0;
      first_q   <= 1'b1;
    end else if (in_acc) begin
      if (last_a) begin
        col_q     <= '0;
        row_sum_q <= '0;
        ring_q    <= ring_next;
        first_q   <= 1'b0;
      end else begin
        col_q     <= col_a + ColAw'(1);
        row_sum_q <= sum_a;
        ring_q    <= ring_a;
        first_q   <= first_a;
      end
    end
  end

  // input stage register
  logic [ColAw-1:0]     s1_col_q;
  logic [IntegralW-1:0] s1_sum_q;
  logic [RingW-1:0]     s1_ring_q;
  logic                 s1_first_q;
  logic                 s1_last_q;
  logic                 byp_q;
  logic [IntegralW-1:0] byp_data_q;
  logic [IntegralW-1:0] above;
  logic [IntegralW-1:0] value;
  logic [IntegralW-1:0] rd_data;
  logic                 wr_en;

  assign wr_en = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q   <= col_a;
      s1_sum_q   <= sum_a;
      s1_ring_q  <= ring_a;
      s1_first_q <= first_a;
      s1_last_q  <= last_a;
      // same column written this edge: memory read returns the old word
      byp_q      <= wr_en && (s1_col_q == col_a);
      byp_data_q <= value;
    end
  end

  // previous-row line memory
  rii_line_mem #(
    .Depth (MAX_WIDTH),
    .DataW (IntegralW),
    .AddrW (ColAw)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_col_q),
    .wdata_i (value),
    .re_i    (in_acc),
    .raddr_i (col_a),
    .rdata_o (rd_data)
  );

  // integral value
  always_comb begin
    if (s1_first_q) begin
      above = '0;
    end else if (byp_q) begin
      above = byp_data_q;
    end else begin
      above = rd_data;
    end
    value = s1_sum_q + above;
  end

  // result register
  logic [IntegralW-1:0] out_value_q;
  logic [ColumnW-1:0]   out_col_q;
  logic [SlotW-1:0]     out_slot_q;
  logic                 out_last_q;
  logic [CntW-1:0]      s1_col_ext;
  logic [RowW-1:0]      s1_ring_ext;

  assign s1_col_ext  = CntW'(s1_col_q);
  assign s1_ring_ext = RowW'(s1_ring_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_value_q <= value;
      out_col_q   <= s1_col_ext[ColumnW-1:0];
      out_slot_q  <= s1_ring_ext[SlotW-1:0];
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_slot_q, out_col_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_row_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_a) |=> (col_q == '0) && (row_sum_q == '0) && !first_q)
    else $error("row end did not restart the row");

  a_frame_start_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser && !last_a) |=> (col_q == ColAw'(1)) && first_q)
    else $error("frame start did not restart at column zero");

endmodule
